[src/pmfb_pkg.sv]
// package: shared constants, codes and types for the page-mode frame buffer engine
`timescale 1ns / 1ps

package pmfb_pkg;

    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;
    localparam int GLYPH_SIZE    = 16;
    localparam int STORE_BYTES   = 1024;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int PAGE_W  = 3;
    localparam int ADDR_W  = 10;
    localparam int BITS_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_GLYPH = 2'd2,
        CMD_READ  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_RD    = 3'd2,
        ST_WR    = 3'd3,
        ST_RESP  = 3'd4
    } state_t;

    // one classified command as it travels from front to back
    typedef struct packed {
        op_t               op;
        logic              set;
        logic              status;
        logic [COL_W-1:0]  c0;
        logic [COL_W-1:0]  c1;
        logic [ROW_W-1:0]  rlo;
        logic [ROW_W-1:0]  rhi;
        logic [3:0]        ybase;
        logic [BITS_W-1:0] bits;
    } cmd_t;

endpackage

[src/pmfb_front.sv]
// front end: accepts stream transfers, clips and classifies them into commands
`timescale 1ns / 1ps

module pmfb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic                q_ready,
    input  logic                clear_busy,
    output logic                q_push,
    output pmfb_pkg::cmd_t      q_wdata
);
    import pmfb_pkg::*;

    logic              flip_reg;
    logic              flip_next;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic [BITS_W-1:0] glyph_bits;
    logic              set_pixels;
    logic [PAGE_W-1:0] read_page;
    logic [COL_W-1:0]  read_column;
    cmd_code_t         command;

    logic              x_ok;
    logic              y_ok;
    logic [8:0]        xw;
    logic [8:0]        yh;
    logic signed [9:0] gy_end;
    logic              g_off;

    assign command     = cmd_code_t'(s_axis_tuser);
    assign pos_x       = s_axis_tdata[8:0];
    assign pos_y       = s_axis_tdata[17:9];
    assign rect_width  = s_axis_tdata[25:18];
    assign rect_height = s_axis_tdata[33:26];
    assign glyph_bits  = s_axis_tdata[49:34];
    assign set_pixels  = s_axis_tdata[50];
    assign read_page   = s_axis_tdata[53:51];
    assign read_column = s_axis_tdata[60:54];

    assign flip_next = cfg_wr_en ? cfg_wr_data : flip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else
        begin
            flip_reg <= flip_next;
        end
    end

    assign s_axis_tready = q_ready && !clear_busy;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    assign x_ok   = (pos_x[8:7] == 2'b00);
    assign y_ok   = !pos_y[8] && (pos_y[7:0] < 8'(PANEL_ROWS));
    assign xw     = {2'b00, pos_x[COL_W-1:0]} + {1'b0, rect_width};
    assign yh     = {3'b000, pos_y[ROW_W-1:0]} + {1'b0, rect_height};
    assign gy_end = {pos_y[8], pos_y} + 10'(GLYPH_SIZE - 1);
    assign g_off  = !x_ok || (!pos_y[8] && (pos_y[7:0] >= 8'(PANEL_ROWS))) || gy_end[9];

    always_comb
    begin
        q_wdata        = '0;
        q_wdata.set    = set_pixels;
        q_wdata.c0     = pos_x[COL_W-1:0];
        q_wdata.c1     = pos_x[COL_W-1:0];
        q_wdata.rlo    = pos_y[ROW_W-1:0];
        q_wdata.rhi    = pos_y[ROW_W-1:0];
        q_wdata.ybase  = pos_y[3:0];
        q_wdata.bits   = '1;
        q_wdata.op     = OP_NONE;
        q_wdata.status = 1'b0;
        case (command)
            CMD_PIXEL:
            begin
                q_wdata.status = !(x_ok && y_ok);
                q_wdata.op     = (x_ok && y_ok) ? OP_WRITE : OP_NONE;
            end
            CMD_FILL:
            begin
                q_wdata.status = !(x_ok && y_ok);
                if (x_ok && y_ok && (rect_width != 8'd0) && (rect_height != 8'd0))
                begin
                    q_wdata.op = OP_WRITE;
                end
                if (xw > 9'(PANEL_COLUMNS))
                begin
                    q_wdata.c1 = COL_W'(PANEL_COLUMNS - 1);
                end
                else
                begin
                    q_wdata.c1 = COL_W'(xw - 9'd1);
                end
                if (yh > 9'(PANEL_ROWS))
                begin
                    q_wdata.rhi = ROW_W'(PANEL_ROWS - 1);
                end
                else
                begin
                    q_wdata.rhi = ROW_W'(yh - 9'd1);
                end
            end
            CMD_GLYPH:
            begin
                q_wdata.status = g_off;
                q_wdata.op     = g_off ? OP_NONE : OP_WRITE;
                q_wdata.bits   = glyph_bits;
                q_wdata.rlo    = pos_y[8] ? '0 : pos_y[ROW_W-1:0];
                if (gy_end >= 10'(PANEL_ROWS - 1))
                begin
                    q_wdata.rhi = ROW_W'(PANEL_ROWS - 1);
                end
                else
                begin
                    q_wdata.rhi = gy_end[ROW_W-1:0];
                end
            end
            CMD_READ:
            begin
                q_wdata.status = ({1'b0, read_page} >= 4'(PANEL_ROWS / 8));
                q_wdata.op     = q_wdata.status ? OP_NONE : OP_READ;
                q_wdata.rlo    = {read_page, 3'b000};
                q_wdata.c0     = flip_reg ? ~read_column : read_column;
            end
            default:
            begin
                q_wdata.op = OP_NONE;
            end
        endcase
    end

endmodule

[src/pmfb_queue.sv]
// small command queue between front and back
`timescale 1ns / 1ps

module pmfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmfb_pkg::cmd_t wdata,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output pmfb_pkg::cmd_t rdata
);
    import pmfb_pkg::*;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign ready = (count_reg != 2'(QUEUE_DEPTH));
    assign valid = (count_reg != 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[src/pmfb_back.sv]
// back end: frame buffer memory, clearing pass and read-modify-write sequencer
`timescale 1ns / 1ps

module pmfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pmfb_pkg::cmd_t q_rdata,
    output logic           q_pop,
    output logic           clear_busy,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,  // read_data
    output logic [0:0]     m_axis_tuser   // status
);
    import pmfb_pkg::*;

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rdata_reg;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_data_next;
    logic              out_status_reg;
    logic              out_status_next;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mask;

    // rows of the current page that the command touches
    always_comb
    begin
        logic [ROW_W-1:0] row;
        logic [3:0]       diff;
        mask = '0;
        for (int r = 0; r < 8; r++)
        begin
            row     = {page_reg, 3'(r)};
            diff    = row[3:0] - cmd_reg.ybase;
            mask[r] = (row >= cmd_reg.rlo) && (row <= cmd_reg.rhi) && cmd_reg.bits[diff];
        end
    end

    assign mem_raddr = {page_reg, col_reg};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        page_next       = page_reg;
        col_next        = col_reg;
        clr_next        = clr_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = {page_reg, col_reg};
        mem_wdata       = cmd_reg.set ? (rdata_reg | mask) : (rdata_reg & ~mask);
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_rdata;
                    page_next = q_rdata.rlo[ROW_W-1:3];
                    col_next  = q_rdata.c0;
                    state_next = (q_rdata.op == OP_NONE) ? ST_RESP : ST_RD;
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = (cmd_reg.op == OP_READ) ? ST_RESP : ST_WR;
            end
            ST_WR:
            begin
                mem_we = 1'b1;
                if (col_reg == cmd_reg.c1)
                begin
                    if (page_reg == cmd_reg.rhi[ROW_W-1:3])
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        page_next  = page_reg + 1'b1;
                        col_next   = cmd_reg.c0;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = (cmd_reg.op == OP_READ) ? rdata_reg : 8'd0;
                    out_status_next = cmd_reg.status;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        page_reg       <= page_next;
        col_reg        <= col_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign clear_busy    = (state_reg == ST_CLEAR);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result while clearing");

    a_no_pop_unless_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) && (cmd_reg.op == OP_WRITE) |=> (state_reg == ST_WR))
        else $error("write did not follow read");

    a_no_mem_op_for_none: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (cmd_reg.op != OP_NONE))
        else $error("memory access for ignored command");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (col_reg >= cmd_reg.c0) && (col_reg <= cmd_reg.c1))
        else $error("column out of range");

endmodule

[src/page_mode_framebuffer_draw_top.sv]
// top level: page-mode monochrome frame buffer drawing engine
// commands pass the command queue, then the sequencer; a read does one memory read before its result
// fill: a read then a write per touched buffer byte, page by page across the clipped columns
// one command in the sequencer at a time; each also passes an idle and a result state
// a two-entry command queue lets up to two further commands be taken while one runs
// reset: clears the 1024-byte buffer byte by byte, no input transfer taken until done
`timescale 1ns / 1ps

module page_mode_framebuffer_draw_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, rect_width, rect_height, glyph_bits, set_pixels, read_page, read_column
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // read_data
    output logic [0:0]  m_axis_tuser   // status
);
    import pmfb_pkg::*;

    cmd_t q_wdata;
    cmd_t q_rdata;
    logic q_push;
    logic q_pop;
    logic q_ready;
    logic q_valid;
    logic clear_busy;

    pmfb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_ready       (q_ready),
        .clear_busy    (clear_busy),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    pmfb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .ready (q_ready),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    pmfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .clear_busy    (clear_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[tb/page_mode_framebuffer_draw_checker.sv]
// checker: shadow frame buffer, reply prediction and comparison for the draw engine
`timescale 1ns / 1ps

module page_mode_framebuffer_draw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          mismatches,
    output int          outstanding
);
    import pmfb_pkg::*;

    typedef struct {
        cmd_code_t  cmd;
        logic [7:0] read_data;
        logic       status;
    } draw_reply_t;

    logic [7:0]  shadow_fb [STORE_BYTES];
    logic        shadow_flip;
    draw_reply_t reply_queue [$];
    int          errs;

    function automatic bit column_on_panel(int x);
        return x >= 0 && x < PANEL_COLUMNS;
    endfunction

    function automatic bit row_on_panel(int y);
        return y >= 0 && y < PANEL_ROWS;
    endfunction

    function automatic void plot(int x, int y, logic set);
        int         idx;
        logic [7:0] mask;
        idx  = ((y >> 3) * PANEL_COLUMNS + x) % STORE_BYTES;
        mask = 8'd1 << (y & 7);
        if (set)
            shadow_fb[idx] = shadow_fb[idx] | mask;
        else
            shadow_fb[idx] = shadow_fb[idx] & ~mask;
    endfunction

    function automatic draw_reply_t run_command(cmd_code_t cmd, logic [63:0] d);
        int          x;
        int          y;
        int          w;
        int          h;
        int          col;
        int          i;
        int          j;
        logic [15:0] bits;
        logic        set;
        int          page;
        draw_reply_t r;
        x    = $signed(d[8:0]);
        y    = $signed(d[17:9]);
        w    = int'(d[25:18]);
        h    = int'(d[33:26]);
        bits = d[49:34];
        set  = d[50];
        page = int'(d[53:51]);
        col  = int'(d[60:54]);
        r.cmd       = cmd;
        r.read_data = 8'd0;
        r.status    = 1'b0;
        case (cmd)
            CMD_PIXEL:
            begin
                if (column_on_panel(x) && row_on_panel(y))
                    plot(x, y, set);
                else
                    r.status = 1'b1;
            end
            CMD_FILL:
            begin
                if (column_on_panel(x) && row_on_panel(y))
                begin
                    if (x + w > PANEL_COLUMNS)
                        w = PANEL_COLUMNS - x;
                    if (y + h > PANEL_ROWS)
                        h = PANEL_ROWS - y;
                    for (i = x; i < x + w; i++)
                        for (j = y; j < y + h; j++)
                            plot(i, j, set);
                end
                else
                    r.status = 1'b1;
            end
            CMD_GLYPH:
            begin
                if (!column_on_panel(x) || y >= PANEL_ROWS || y + GLYPH_SIZE <= 0)
                    r.status = 1'b1;
                else
                begin
                    for (j = 0; j < GLYPH_SIZE && j < 16; j++)
                        if (bits[j] && row_on_panel(y + j))
                            plot(x, y + j, set);
                end
            end
            default:
            begin
                if (page >= PANEL_ROWS / 8)
                    r.status = 1'b1;
                else
                begin
                    if (shadow_flip)
                        col = (PANEL_COLUMNS - 1) - col;
                    r.read_data = shadow_fb[(page * PANEL_COLUMNS + col) % STORE_BYTES];
                end
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string what);
        errs++;
        if (errs <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        draw_reply_t oldest;
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_BYTES; k++)
                shadow_fb[k] = 8'd0;
            shadow_flip = 1'b0;
            reply_queue.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                shadow_flip = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_queue.size() == 0)
                    note_mismatch($sformatf("unexpected reply read_data %02h status %0d",
                                            m_axis_tdata, m_axis_tuser[0]));
                else
                begin
                    oldest = reply_queue.pop_front();
                    if (m_axis_tdata !== oldest.read_data)
                        note_mismatch($sformatf("%s read_data exp %02h got %02h",
                                                oldest.cmd.name(), oldest.read_data,
                                                m_axis_tdata));
                    if (m_axis_tuser[0] !== oldest.status)
                        note_mismatch($sformatf("%s status exp %0d got %0d",
                                                oldest.cmd.name(), oldest.status,
                                                m_axis_tuser[0]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                reply_queue.push_back(run_command(cmd_code_t'(s_axis_tuser), s_axis_tdata));
            mismatches  <= errs;
            outstanding <= reply_queue.size();
        end
    end

endmodule

[tb/page_mode_framebuffer_draw_top_test.sv]
// testbench top: stimulus, flip register phases and verdict for the draw engine
`timescale 1ns / 1ps

module page_mode_framebuffer_draw_top_test;
    import pmfb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // pos_x, pos_y, rect_width, rect_height, glyph_bits, set_pixels, read_page, read_column
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;  // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // read_data
    logic [0:0]  m_axis_tuser;  // status
    bit          idle_on = 1'b1;
    int          mismatches;
    int          outstanding;

    page_mode_framebuffer_draw_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_mode_framebuffer_draw_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 25);

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] pack_fields(int x, int y, int w, int h, int bits,
                                                int set, int page, int col);
        logic [63:0] d;
        d        = '0;
        d[8:0]   = x[8:0];
        d[17:9]  = y[8:0];
        d[25:18] = w[7:0];
        d[33:26] = h[7:0];
        d[49:34] = bits[15:0];
        d[50]    = set[0];
        d[53:51] = page[2:0];
        d[60:54] = col[6:0];
        return d;
    endfunction

    task automatic push_command(cmd_code_t cmd, logic [63:0] d);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(0, 99) < 25)
                gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_flip(bit v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_command(output cmd_code_t cmd, output logic [63:0] d);
        int pick;
        int x;
        int y;
        int w;
        int h;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            cmd = CMD_PIXEL;
        else if (pick < 45)
            cmd = CMD_FILL;
        else if (pick < 75)
            cmd = CMD_GLYPH;
        else
            cmd = CMD_READ;
        if ($urandom_range(0, 99) < 85)
            x = $urandom_range(0, PANEL_COLUMNS - 1);
        else
            x = int'($urandom_range(0, 383)) - 128;
        if ($urandom_range(0, 99) >= 85)
            y = int'($urandom_range(0, 383)) - 128;
        else if (cmd == CMD_GLYPH)
            y = int'($urandom_range(0, PANEL_ROWS + GLYPH_SIZE - 2)) - (GLYPH_SIZE - 1);
        else
            y = $urandom_range(0, PANEL_ROWS - 1);
        // most fills stay small so the run stays short
        if (cmd == CMD_FILL && $urandom_range(0, 99) < 95)
        begin
            w = $urandom_range(0, 16);
            h = $urandom_range(0, 16);
        end
        else
        begin
            w = $urandom_range(0, 255);
            h = $urandom_range(0, 255);
        end
        d = pack_fields(x, y, w, h, $urandom_range(0, 65535), $urandom_range(0, 1),
                        $urandom_range(0, 7), $urandom_range(0, 127));
    endtask

    initial
    begin
        cmd_code_t   cmd;
        logic [63:0] d;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PIXEL;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_flip(1'b0);
        // corners, off-panel pixels
        push_command(CMD_PIXEL, pack_fields(0, 0, 0, 0, 0, 1, 0, 0));
        push_command(CMD_PIXEL, pack_fields(127, 63, 0, 0, 0, 1, 0, 0));
        push_command(CMD_PIXEL, pack_fields(-1, 0, 0, 0, 0, 1, 0, 0));
        push_command(CMD_PIXEL, pack_fields(128, 5, 0, 0, 0, 1, 0, 0));
        push_command(CMD_PIXEL, pack_fields(3, 64, 0, 0, 0, 1, 0, 0));
        push_command(CMD_PIXEL, pack_fields(255, -128, 255, 255, 65535, 1, 7, 127));
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 7, 127));
        // full panel, empty, off-panel and clipped rectangles
        push_command(CMD_FILL, pack_fields(0, 0, 255, 255, 0, 1, 0, 0));
        push_command(CMD_FILL, pack_fields(5, 5, 0, 10, 0, 0, 0, 0));
        push_command(CMD_FILL, pack_fields(5, 5, 10, 0, 0, 0, 0, 0));
        push_command(CMD_FILL, pack_fields(-5, 0, 10, 10, 0, 0, 0, 0));
        push_command(CMD_FILL, pack_fields(10, 60, 20, 10, 0, 0, 0, 0));
        push_command(CMD_FILL, pack_fields(120, 8, 255, 1, 0, 0, 0, 0));
        // glyph columns across the top and bottom edges, off-panel columns and a patterned column
        push_command(CMD_GLYPH, pack_fields(4, -15, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(4, -16, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(9, 63, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(9, 64, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(128, 10, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(-128, 10, 0, 0, 65535, 0, 0, 0));
        push_command(CMD_GLYPH, pack_fields(0, 24, 0, 0, 16'hA5C3, 0, 0, 0));
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 4));
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 3, 0));
        write_flip(1'b1);
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
        push_command(CMD_READ, pack_fields(0, 0, 0, 0, 0, 0, 7, 127));

        for (int phase = 0; phase < 4; phase++)
        begin
            write_flip(phase[0]);
            idle_on <= (phase != 2);
            for (int n = 0; n < 232; n++)
            begin
                random_command(cmd, d);
                push_command(cmd, d);
            end
        end

        drain();
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
